[src/bafd_pkg.sv]
// ----------------------------------------------------------------------------
// bafd_pkg
// Shared types, constants and the LLC header table for the bridged ATM
// frame deframer.
// ----------------------------------------------------------------------------
package bafd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned TYPE_W     = 16;
    localparam int unsigned POS_W      = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_status STATUS_ACCEPTED   = 3'd0;
    localparam t_status STATUS_BAD_HEADER = 3'd1;
    localparam t_status STATUS_TOO_SHORT  = 3'd2;
    localparam t_status STATUS_FILTERED   = 3'd3;
    localparam t_status STATUS_LINK_DOWN  = 3'd4;

    localparam t_cfg_index CFG_LLC_MODE      = 2'd0;
    localparam t_cfg_index CFG_FILTER_MASK   = 2'd1;
    localparam t_cfg_index CFG_FILTER_PREFIX = 2'd2;
    localparam t_cfg_index CFG_LINK_UP       = 2'd3;

    localparam logic [POS_W-1:0] LLC_HDR_LEN   = 8'd10;
    localparam logic [POS_W-1:0] VC_HDR_LEN    = 8'd2;
    localparam logic [POS_W-1:0] LLC_CHECK_LEN = 8'd7;
    localparam logic [POS_W-1:0] ETH_HDR_LEN   = 8'd14;
    localparam logic [POS_W-1:0] OFF_TYPE_HI   = 8'd12;
    localparam logic [POS_W-1:0] OFF_TYPE_LO   = 8'd13;
    localparam logic [POS_W-1:0] OFF_IP_FIRST  = 8'd30;
    localparam logic [POS_W-1:0] OFF_IP_LAST   = 8'd33;
    localparam logic [POS_W-1:0] ADDR_DONE_LEN = 8'd34;
    localparam logic [POS_W-1:0] POS_MAX       = 8'hFF;

    localparam logic [TYPE_W-1:0] TYPE_IPV4 = 16'h0800;
    localparam logic [TYPE_W-1:0] TYPE_ARP  = 16'h0806;

    typedef struct packed {
        logic              llc_mode;
        logic [ADDR_W-1:0] filter_mask;
        logic [ADDR_W-1:0] filter_prefix;
        logic              link_up;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] pdu_byte;
        logic              pdu_last;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              byte_valid;
        logic              frame_end;
        t_status           frame_status;
    } t_result;

    // LLC/SNAP bridged header: AA AA 03 00 80 C2 00
    function automatic logic [BYTE_W-1:0] llc_expect(input logic [2:0] idx);
        logic [BYTE_W-1:0] val;
        case (idx)
            3'd0:    val = 8'hAA;
            3'd1:    val = 8'hAA;
            3'd2:    val = 8'h03;
            3'd3:    val = 8'h00;
            3'd4:    val = 8'h80;
            3'd5:    val = 8'hC2;
            3'd6:    val = 8'h00;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

[src/bafd_in_if.sv]
// ----------------------------------------------------------------------------
// bafd_in_if
// PDU byte stream channel: valid/ready with one byte and a last flag.
// ----------------------------------------------------------------------------
interface bafd_in_if;
    logic                         valid;
    logic                         ready;
    logic [bafd_pkg::BYTE_W-1:0]  pdu_byte;
    logic                         pdu_last;

    modport source (output valid, output pdu_byte, output pdu_last, input ready);
    modport sink   (input valid, input pdu_byte, input pdu_last, output ready);
endinterface

[src/bafd_out_if.sv]
// ----------------------------------------------------------------------------
// bafd_out_if
// Ethernet frame byte channel: valid/ready with byte, flags and end status.
// ----------------------------------------------------------------------------
interface bafd_out_if;
    logic                          valid;
    logic                          ready;
    logic [bafd_pkg::BYTE_W-1:0]   frame_byte;
    logic                          byte_valid;
    logic                          frame_end;
    logic [bafd_pkg::STATUS_W-1:0] frame_status;

    modport source (output valid, output frame_byte, output byte_valid,
                    output frame_end, output frame_status, input ready);
    modport sink   (input valid, input frame_byte, input byte_valid,
                    input frame_end, input frame_status, output ready);
endinterface

[src/bafd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bafd_cfg_regs
// Configuration register file: mode, IPv4 filter mask/prefix and link state.
// ----------------------------------------------------------------------------
module bafd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  bafd_pkg::t_cfg_index                i_cfg_index,
    input  logic [bafd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output bafd_pkg::t_cfg                      o_cfg
);

    bafd_pkg::t_cfg r_cfg;
    bafd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bafd_pkg::CFG_LLC_MODE:      n_cfg.llc_mode      = i_cfg_data[0];
                bafd_pkg::CFG_FILTER_MASK:   n_cfg.filter_mask   = i_cfg_data;
                bafd_pkg::CFG_FILTER_PREFIX: n_cfg.filter_prefix = i_cfg_data;
                bafd_pkg::CFG_LINK_UP:       n_cfg.link_up       = i_cfg_data[0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.llc_mode      <= 1'b1;
            r_cfg.filter_mask   <= '0;
            r_cfg.filter_prefix <= '0;
            r_cfg.link_up       <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/bafd_frame_state.sv]
// ----------------------------------------------------------------------------
// bafd_frame_state
// Per-PDU tracking: byte position, header check, EtherType and IPv4
// destination capture, and the end-of-frame status decision.
// ----------------------------------------------------------------------------
module bafd_frame_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bafd_pkg::t_cfg    i_cfg,
    input  logic              i_step,
    input  bafd_pkg::t_item   i_item,
    output logic              o_has_result,
    output bafd_pkg::t_result o_result
);

    logic [bafd_pkg::POS_W-1:0]  r_pos,   n_pos;
    logic                        r_hgood, n_hgood;
    logic [bafd_pkg::TYPE_W-1:0] r_etype, n_etype;
    logic [bafd_pkg::ADDR_W-1:0] r_ipdst, n_ipdst;

    logic [bafd_pkg::POS_W-1:0]  hlen;
    logic [bafd_pkg::POS_W-1:0]  off;
    logic [bafd_pkg::POS_W-1:0]  pos_inc;
    logic                        payload;
    logic                        hdr_fail;
    logic                        hgood_upd;
    logic                        addr_done;
    logic                        pass;
    logic [bafd_pkg::TYPE_W-1:0] etype_upd;
    logic [bafd_pkg::ADDR_W-1:0] ipdst_upd;
    bafd_pkg::t_status           status;

    always_comb begin
        hlen    = i_cfg.llc_mode ? bafd_pkg::LLC_HDR_LEN : bafd_pkg::VC_HDR_LEN;
        payload = (r_pos >= hlen);
        off     = r_pos - hlen;

        if (i_cfg.llc_mode) begin
            hdr_fail = (r_pos < bafd_pkg::LLC_CHECK_LEN) &&
                       (i_item.pdu_byte != bafd_pkg::llc_expect(r_pos[2:0]));
        end else begin
            hdr_fail = (r_pos < bafd_pkg::VC_HDR_LEN) && (i_item.pdu_byte != 8'h00);
        end
        hgood_upd = r_hgood && !hdr_fail;

        etype_upd = r_etype;
        if (payload && (off == bafd_pkg::OFF_TYPE_HI || off == bafd_pkg::OFF_TYPE_LO)) begin
            etype_upd = {r_etype[bafd_pkg::TYPE_W-bafd_pkg::BYTE_W-1:0], i_item.pdu_byte};
        end
        ipdst_upd = r_ipdst;
        if (payload && (off >= bafd_pkg::OFF_IP_FIRST) && (off <= bafd_pkg::OFF_IP_LAST)) begin
            ipdst_upd = {r_ipdst[bafd_pkg::ADDR_W-bafd_pkg::BYTE_W-1:0], i_item.pdu_byte};
        end

        pos_inc   = (r_pos == bafd_pkg::POS_MAX) ? r_pos : r_pos + 8'd1;
        // pos_inc is the PDU length when this is the last byte
        addr_done = (pos_inc >= hlen + bafd_pkg::ADDR_DONE_LEN);

        if (i_cfg.filter_mask == '0) begin
            pass = 1'b1;
        end else if (etype_upd == bafd_pkg::TYPE_IPV4 && addr_done &&
                     (ipdst_upd & i_cfg.filter_mask) == i_cfg.filter_prefix) begin
            pass = 1'b1;
        end else begin
            pass = (etype_upd == bafd_pkg::TYPE_ARP);
        end

        if (!hgood_upd) begin
            status = bafd_pkg::STATUS_BAD_HEADER;
        end else if (pos_inc < hlen + bafd_pkg::ETH_HDR_LEN) begin
            status = bafd_pkg::STATUS_TOO_SHORT;
        end else if (!pass) begin
            status = bafd_pkg::STATUS_FILTERED;
        end else if (!i_cfg.link_up) begin
            status = bafd_pkg::STATUS_LINK_DOWN;
        end else begin
            status = bafd_pkg::STATUS_ACCEPTED;
        end

        n_pos   = r_pos;
        n_hgood = r_hgood;
        n_etype = r_etype;
        n_ipdst = r_ipdst;
        if (i_step) begin
            if (i_item.pdu_last) begin
                n_pos   = '0;
                n_hgood = 1'b1;
                n_etype = '0;
                n_ipdst = '0;
            end else begin
                n_pos   = pos_inc;
                n_hgood = hgood_upd;
                n_etype = etype_upd;
                n_ipdst = ipdst_upd;
            end
        end

        o_has_result          = i_item.pdu_last || payload;
        o_result.frame_byte   = payload ? i_item.pdu_byte : 8'h00;
        o_result.byte_valid   = payload;
        o_result.frame_end    = i_item.pdu_last;
        o_result.frame_status = i_item.pdu_last ? status : bafd_pkg::STATUS_ACCEPTED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hgood <= 1'b1;
            r_etype <= '0;
            r_ipdst <= '0;
        end else begin
            r_pos   <= n_pos;
            r_hgood <= n_hgood;
            r_etype <= n_etype;
            r_ipdst <= n_ipdst;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.pdu_last |=> r_pos == '0 && r_hgood && r_etype == '0)
        else $error("frame state not cleared after last byte");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_item.pdu_last && r_pos != bafd_pkg::POS_MAX
        |=> r_pos == 8'($past(r_pos) + 8'd1))
        else $error("byte position did not advance");

endmodule

[src/bridged_atm_frame_deframer.sv]
// ----------------------------------------------------------------------------
// bridged_atm_frame_deframer
// Bridged Ethernet decapsulation of AAL5 PDUs (LLC/SNAP or VC-mux), with
// header check, IPv4 destination filter and end-of-frame status.
// ----------------------------------------------------------------------------
// One PDU byte is taken per clock while the output is not stalled. Each
// transfer lands in an input register; when the output register is free the
// frame-state logic checks the header byte, shifts in the EtherType/IPv4
// destination and, on the last byte, decides the status, and the result is
// written to the output register. Header bytes other than the last byte give
// no result. The frame state is updated once per byte; a stalled output holds
// the input side only once both registers are full. Configuration is taken
// through a plain write port and should be changed only between PDUs.
// ----------------------------------------------------------------------------
module bridged_atm_frame_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  bafd_pkg::t_cfg_index            i_cfg_index,
    input  logic [bafd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bafd_in_if.sink                         i_pdu,
    bafd_out_if.source                      o_frame
);

    bafd_pkg::t_cfg    cfg;
    bafd_pkg::t_item   in_item;
    bafd_pkg::t_result step_result;
    logic              step_has_result;

    logic              r_in_valid, n_in_valid;
    bafd_pkg::t_item   r_in;
    logic              r_out_valid, n_out_valid;
    bafd_pkg::t_result r_out;

    logic              out_free;
    logic              advance;
    logic              in_ready;

    bafd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bafd_frame_state u_frame_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_step       (advance),
        .i_item       (r_in),
        .o_has_result (step_has_result),
        .o_result     (step_result)
    );

    assign in_item.pdu_byte = i_pdu.pdu_byte;
    assign in_item.pdu_last = i_pdu.pdu_last;

    assign out_free = !r_out_valid || o_frame.ready;
    assign advance  = r_in_valid && out_free;
    assign in_ready = !r_in_valid || advance;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (in_ready) begin
            n_in_valid = i_pdu.valid;
        end
        if (out_free) begin
            n_out_valid = advance && step_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pdu.valid && in_ready) begin
            r_in <= in_item;
        end
        if (advance && step_has_result) begin
            r_out <= step_result;
        end
    end

    assign i_pdu.ready          = in_ready;
    assign o_frame.valid        = r_out_valid;
    assign o_frame.frame_byte   = r_out.frame_byte;
    assign o_frame.byte_valid   = r_out.byte_valid;
    assign o_frame.frame_end    = r_out.frame_end;
    assign o_frame.frame_status = r_out.frame_status;

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.byte_valid || r_out.frame_end)
        else $error("result carries neither a byte nor a frame end");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.frame_end |-> r_out.frame_status == bafd_pkg::STATUS_ACCEPTED)
        else $error("status given on a result that is not a frame end");

    a_no_step_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_frame.ready |-> !advance)
        else $error("frame state stepped while the output is blocked");

endmodule
